// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types, constants and microprogram for the min-heap queue
// Holds the storage geometry, the status codes, the control word layout and
// the read-only microprogram that sequences inserts and extracts.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int CAPACITY     = 64;
	localparam int KEY_BITS     = 32;
	localparam int PAYLOAD_BITS = 16;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KID_W = CNT_W + 1;
	localparam int PC_W  = 4;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [KID_W-1:0]        kid_t;
	typedef logic [PC_W-1:0]         pc_t;
	typedef logic [KEY_BITS-1:0]     key_t;
	typedef logic [PAYLOAD_BITS-1:0] pay_t;

	typedef struct packed {
		key_t key;
		pay_t pay;
	} entry_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Datapath action selected by one control word
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_INS_SETUP,
		ACT_RD_PARENT,
		ACT_UP_STEP,
		ACT_WR_CUR,
		ACT_EXT_SETUP,
		ACT_LOAD_LAST,
		ACT_RD_KIDS,
		ACT_DOWN_STEP,
		ACT_FINISH
	} act_t;

	// Jump condition; on a hit the step counter loads the target
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_FULL,
		COND_AT_ROOT,
		COND_UP_MOVED,
		COND_EXT_NONE,
		COND_NO_KIDS,
		COND_DOWN_MOVED
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	// Program step addresses
	localparam pc_t PC_INS_START = 4'd0;
	localparam pc_t PC_INS_LOOP  = 4'd1;
	localparam pc_t PC_INS_CMP   = 4'd2;
	localparam pc_t PC_INS_PLACE = 4'd3;
	localparam pc_t PC_EXT_START = 4'd4;
	localparam pc_t PC_EXT_LOAD  = 4'd5;
	localparam pc_t PC_EXT_LOOP  = 4'd6;
	localparam pc_t PC_EXT_CMP   = 4'd7;
	localparam pc_t PC_EXT_PLACE = 4'd8;
	localparam pc_t PC_FIN       = 4'd9;

	function automatic ctrl_word_t ucode(input pc_t pc);
		ctrl_word_t cw;
		case (pc)
			PC_INS_START: cw = '{ACT_INS_SETUP, COND_FULL,       PC_FIN};
			PC_INS_LOOP:  cw = '{ACT_RD_PARENT, COND_AT_ROOT,    PC_INS_PLACE};
			PC_INS_CMP:   cw = '{ACT_UP_STEP,   COND_UP_MOVED,   PC_INS_LOOP};
			PC_INS_PLACE: cw = '{ACT_WR_CUR,    COND_ALWAYS,     PC_FIN};
			PC_EXT_START: cw = '{ACT_EXT_SETUP, COND_EXT_NONE,   PC_FIN};
			PC_EXT_LOAD:  cw = '{ACT_LOAD_LAST, COND_NEVER,      PC_FIN};
			PC_EXT_LOOP:  cw = '{ACT_RD_KIDS,   COND_NO_KIDS,    PC_EXT_PLACE};
			PC_EXT_CMP:   cw = '{ACT_DOWN_STEP, COND_DOWN_MOVED, PC_EXT_LOOP};
			PC_EXT_PLACE: cw = '{ACT_WR_CUR,    COND_ALWAYS,     PC_FIN};
			PC_FIN:       cw = '{ACT_FINISH,    COND_NEVER,      PC_FIN};
			default:      cw = '{ACT_NOP,       COND_ALWAYS,     PC_FIN};
		endcase
		return cw;
	endfunction

endpackage

// ===== rtl/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue: microcoded binary min-heap priority queue
// Keeps up to CAPACITY (key, payload) entries in a heap store and serves
// inserts and minimum extracts, one item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a rising edge where start is high and
//   busy is low. kind = 0 inserts (new_key, new_payload); kind = 1 extracts the
//   entry with the smallest key. Equal keys are never swapped.
//   Result channel: done is high for exactly one cycle and qualifies status,
//   removed_key/removed_payload (zero unless an entry left), min_key/
//   min_payload (root after the item, zero when empty), is_empty and
//   entry_total. The receiver cannot stall; each result shows only once.
//   Sequencing: a step counter walks a ten-word microprogram. Each heap level
//   takes a registered memory read, then a compare and move. Refused items and
//   extracts that empty the heap go from the setup step straight to the finish
//   step. The longest item is an insert climbing all six levels (64 entries).
//   busy falls in the cycle where done rises, so the next item may be given in
//   that same cycle.
//   Reset: arst_n clears the entry count and the sequencer; the store itself
//   is not cleared, since entries beyond the count are never used.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [bmhq_pkg::KEY_BITS-1:0]     new_key,
	input  logic [bmhq_pkg::PAYLOAD_BITS-1:0] new_payload,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [bmhq_pkg::KEY_BITS-1:0]     removed_key,
	output logic [bmhq_pkg::PAYLOAD_BITS-1:0] removed_payload,
	output logic [bmhq_pkg::KEY_BITS-1:0]     min_key,
	output logic [bmhq_pkg::PAYLOAD_BITS-1:0] min_payload,
	output logic                              is_empty,
	output logic [bmhq_pkg::CNT_W-1:0]        entry_total
);

	// Heap store: one write port, two registered read ports
	bmhq_pkg::entry_t heap_mem [bmhq_pkg::CAPACITY];
	bmhq_pkg::entry_t rd0_q, rd1_q;

	// Sequencer
	logic               busy_q, done_q;
	bmhq_pkg::pc_t      pc_q, pc_d;
	bmhq_pkg::ctrl_word_t cw;
	logic               cond_hit;

	// Datapath registers
	bmhq_pkg::cnt_t     count_q;
	bmhq_pkg::idx_t     pos_q;
	bmhq_pkg::entry_t   cur_q;       // the entry being sifted, held out of the store
	bmhq_pkg::entry_t   root_q;      // shadow of store entry 0
	bmhq_pkg::status_t  status_q;
	bmhq_pkg::entry_t   removed_q;
	bmhq_pkg::entry_t   min_q;
	logic               empty_q;
	bmhq_pkg::cnt_t     total_q;

	// Address arithmetic and compares
	bmhq_pkg::idx_t     parent;
	bmhq_pkg::kid_t     kid_l, kid_r;
	logic               l_valid, r_valid;
	logic               take_l, take_r, down_moved, up_moved;
	bmhq_pkg::key_t     best_key;
	logic               is_full;

	// Memory access for this step
	logic               mem_we;
	bmhq_pkg::idx_t     mem_waddr, raddr0, raddr1;
	bmhq_pkg::entry_t   mem_wdata;

	assign cw = bmhq_pkg::ucode(pc_q);

	assign parent  = (pos_q - bmhq_pkg::IDX_W'(1)) >> 1;
	assign kid_l   = {1'b0, pos_q, 1'b1};
	assign kid_r   = kid_l + bmhq_pkg::KID_W'(1);
	assign l_valid = kid_l < bmhq_pkg::KID_W'(count_q);
	assign r_valid = kid_r < bmhq_pkg::KID_W'(count_q);
	assign is_full = count_q == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY);

	// Sift-up: move the parent down while the held entry is strictly smaller
	assign up_moved = cur_q.key < rd0_q.key;

	// Sift-down: left child if strictly smaller, then right if strictly smaller still
	assign take_l     = l_valid && (rd0_q.key < cur_q.key);
	assign best_key   = take_l ? rd0_q.key : cur_q.key;
	assign take_r     = r_valid && (rd1_q.key < best_key);
	assign down_moved = take_l || take_r;

	always_comb begin
		case (cw.cond)
			bmhq_pkg::COND_NEVER:      cond_hit = 1'b0;
			bmhq_pkg::COND_ALWAYS:     cond_hit = 1'b1;
			bmhq_pkg::COND_FULL:       cond_hit = is_full;
			bmhq_pkg::COND_AT_ROOT:    cond_hit = pos_q == '0;
			bmhq_pkg::COND_UP_MOVED:   cond_hit = up_moved;
			bmhq_pkg::COND_EXT_NONE:   cond_hit = count_q <= bmhq_pkg::CNT_W'(1);
			bmhq_pkg::COND_NO_KIDS:    cond_hit = !l_valid;
			bmhq_pkg::COND_DOWN_MOVED: cond_hit = down_moved;
			default:                   cond_hit = 1'b0;
		endcase
		pc_d = cond_hit ? cw.target : pc_q + bmhq_pkg::PC_W'(1);
	end

	// Memory port control per action
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = cur_q;
		raddr0    = '0;
		raddr1    = '0;
		if (busy_q) begin
			case (cw.act)
				bmhq_pkg::ACT_RD_PARENT: raddr0 = parent;
				bmhq_pkg::ACT_UP_STEP: begin
					mem_we    = up_moved;
					mem_wdata = rd0_q;
				end
				bmhq_pkg::ACT_WR_CUR:    mem_we = 1'b1;
				bmhq_pkg::ACT_EXT_SETUP:
					raddr0 = bmhq_pkg::IDX_W'(count_q - bmhq_pkg::CNT_W'(1));
				bmhq_pkg::ACT_RD_KIDS: begin
					raddr0 = kid_l[bmhq_pkg::IDX_W-1:0];
					raddr1 = kid_r[bmhq_pkg::IDX_W-1:0];
				end
				bmhq_pkg::ACT_DOWN_STEP: begin
					mem_we    = down_moved;
					mem_wdata = take_r ? rd1_q : rd0_q;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[mem_waddr] <= mem_wdata;
		end
		rd0_q <= heap_mem[raddr0];
		rd1_q <= heap_mem[raddr1];
	end

	// Control state: sequencer, entry count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			pc_q    <= bmhq_pkg::PC_FIN;
			count_q <= '0;
		end else begin
			// Raise the strobe for one cycle after the finish step
			done_q <= busy_q && (cw.act == bmhq_pkg::ACT_FINISH);
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					pc_q   <= kind ? bmhq_pkg::PC_EXT_START : bmhq_pkg::PC_INS_START;
				end
			end else begin
				pc_q <= pc_d;
				case (cw.act)
					bmhq_pkg::ACT_INS_SETUP: begin
						if (!is_full) begin
							count_q <= count_q + bmhq_pkg::CNT_W'(1);
						end
					end
					bmhq_pkg::ACT_EXT_SETUP: begin
						if (count_q != '0) begin
							count_q <= count_q - bmhq_pkg::CNT_W'(1);
						end
					end
					bmhq_pkg::ACT_FINISH: begin
						busy_q <= 1'b0;
					end
					default: begin
						busy_q <= busy_q;
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
		if (!busy_q) begin
			if (start) begin
				cur_q <= '{key: new_key, pay: new_payload};
			end
		end else begin
			case (cw.act)
				bmhq_pkg::ACT_INS_SETUP: begin
					pos_q     <= count_q[bmhq_pkg::IDX_W-1:0];
					status_q  <= is_full ? bmhq_pkg::ST_FULL : bmhq_pkg::ST_OK;
					removed_q <= '0;
				end
				bmhq_pkg::ACT_UP_STEP: begin
					if (up_moved) begin
						pos_q <= parent;
					end
				end
				bmhq_pkg::ACT_EXT_SETUP: begin
					if (count_q == '0) begin
						status_q  <= bmhq_pkg::ST_EMPTY;
						removed_q <= '0;
					end else begin
						status_q  <= bmhq_pkg::ST_OK;
						removed_q <= root_q;
					end
				end
				bmhq_pkg::ACT_LOAD_LAST: begin
					cur_q <= rd0_q;
					pos_q <= '0;
				end
				bmhq_pkg::ACT_DOWN_STEP: begin
					if (take_r) begin
						pos_q <= kid_r[bmhq_pkg::IDX_W-1:0];
					end else if (take_l) begin
						pos_q <= kid_l[bmhq_pkg::IDX_W-1:0];
					end
				end
				bmhq_pkg::ACT_FINISH: begin
					// Latch the view of the heap after the item
					min_q   <= (count_q != '0) ? root_q : '0;
					empty_q <= count_q == '0;
					total_q <= count_q;
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	assign busy            = busy_q;
	assign done            = done_q;
	assign status          = status_q;
	assign removed_key     = removed_q.key;
	assign removed_payload = removed_q.pay;
	assign min_key         = min_q.key;
	assign min_payload     = min_q.pay;
	assign is_empty        = empty_q;
	assign entry_total     = total_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bmhq_pkg::ST_FULL) |->
		entry_total == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
		else $error("full status with room left");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bmhq_pkg::ST_OK) |-> (removed_key == '0 && removed_payload == '0))
		else $error("refused item reports a removed entry");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (entry_total == '0)))
		else $error("empty flag disagrees with count");

endmodule

// ===== test/binary_min_heap_queue_test.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_test: self-checking bench for the min-heap queue
// Runs a short directed table (empty refusals, key extremes, equal keys),
// then about 700 random insert/extract items in fill, drain and mixed
// phases. Each result is checked against the shadow heap or a typed-in result.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD       = 8;
	localparam int RESET_CYCLES = 12;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_LIMIT  = 400;
	localparam int TAIL_CYCLES  = 25;
	localparam int PHASE_ITEMS  = 80;
	localparam int PHASES       = 9;
	localparam int MAX_GAP      = 11;

	// Item kinds as seen on the kind port
	localparam logic KIND_INS = 1'b0;
	localparam logic KIND_EXT = 1'b1;

	// Percentage of inserts in each random phase
	localparam int FILL_PCT  = 95;
	localparam int DRAIN_PCT = 5;
	localparam int MIX_PCT   = 55;

	// One result as the block reports it
	typedef struct packed {
		bmhq_pkg::status_t status;
		bmhq_pkg::key_t    gone_key;
		bmhq_pkg::pay_t    gone_pay;
		bmhq_pkg::key_t    root_key;
		bmhq_pkg::pay_t    root_pay;
		logic              empty;
		bmhq_pkg::cnt_t    count;
	} result_t;

	// Result typed into a table row; valid is low where the heap model decides
	typedef struct packed {
		logic    valid;
		result_t res;
	} pinned_t;

	typedef struct packed {
		logic           kind;
		bmhq_pkg::key_t key;
		bmhq_pkg::pay_t pay;
		pinned_t        pin;
	} row_t;

	localparam result_t NO_RESULT = '{status: bmhq_pkg::ST_OK, default: '0};
	localparam int      ROWS      = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic kind = KIND_INS;
	bmhq_pkg::key_t new_key = '0;
	bmhq_pkg::pay_t new_payload = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	bmhq_pkg::key_t removed_key;
	bmhq_pkg::pay_t removed_payload;
	bmhq_pkg::key_t min_key;
	bmhq_pkg::pay_t min_payload;
	logic is_empty;
	bmhq_pkg::cnt_t entry_total;

	// Shadow heap
	bmhq_pkg::entry_t heap_shadow [bmhq_pkg::CAPACITY];
	int     held = 0;

	result_t expected_q [$];
	pinned_t pinned_q [$];
	result_t want;
	result_t predicted;
	pinned_t pin_now;
	int      mismatches = 0;
	int      cycle_count = 0;
	logic    no_idle = 1'b0;

	// Directed table. Results are typed in only where they are obvious: refusals,
	// the first inserts into an empty heap, and the last entry leaving the heap.
	row_t plan [ROWS] = '{
		// extract on an empty heap is refused
		'{KIND_EXT, 32'h0, 16'h0,
			'{1'b1, '{bmhq_pkg::ST_EMPTY, 32'h0, 16'h0, 32'h0, 16'h0, 1'b1, 7'd0}}},
		'{KIND_INS, 32'hFFFF_FFFF, 16'hFFFF,
			'{1'b1, '{bmhq_pkg::ST_OK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 7'd1}}},
		'{KIND_INS, 32'h0, 16'h0,
			'{1'b1, '{bmhq_pkg::ST_OK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0, 7'd2}}},
		'{KIND_INS, 32'h8000_0000, 16'h8000,
			'{1'b1, '{bmhq_pkg::ST_OK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0, 7'd3}}},
		// equal keys with distinct payloads: order among them must hold
		'{KIND_INS, 32'h8000_0000, 16'h1111, '{1'b0, NO_RESULT}},
		'{KIND_INS, 32'h8000_0000, 16'h2222, '{1'b0, NO_RESULT}},
		'{KIND_INS, 32'h7FFF_FFFF, 16'hAAAA, '{1'b0, NO_RESULT}},
		'{KIND_INS, 32'h0000_0001, 16'h5555, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0, '{1'b0, NO_RESULT}},
		// only the largest key is left; taking it empties the heap
		'{KIND_EXT, 32'h0, 16'h0,
			'{1'b1, '{bmhq_pkg::ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 1'b1, 7'd0}}},
		'{KIND_EXT, 32'h0, 16'h0,
			'{1'b1, '{bmhq_pkg::ST_EMPTY, 32'h0, 16'h0, 32'h0, 16'h0, 1'b1, 7'd0}}},
		'{KIND_INS, 32'h0, 16'hFFFF,
			'{1'b1, '{bmhq_pkg::ST_OK, 32'h0, 16'h0, 32'h0, 16'hFFFF, 1'b0, 7'd1}}},
		// same key as the root: must stay below it
		'{KIND_INS, 32'h0, 16'h0001, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0, '{1'b0, NO_RESULT}},
		'{KIND_EXT, 32'h0, 16'h0,
			'{1'b1, '{bmhq_pkg::ST_OK, 32'h0, 16'h0001, 32'h0, 16'h0, 1'b1, 7'd0}}}
	};

	binary_min_heap_queue i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.new_key         (new_key),
		.new_payload     (new_payload),
		.done            (done),
		.status          (status),
		.removed_key     (removed_key),
		.removed_payload (removed_payload),
		.min_key         (min_key),
		.min_payload     (min_payload),
		.is_empty        (is_empty),
		.entry_total     (entry_total)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Apply one item to the shadow heap and return what the block must report.
	// Sift-up swaps only on a strictly smaller key; sift-down takes the left
	// child if strictly smaller, then the right child if smaller than that.
	function automatic result_t heap_apply(input logic op, input bmhq_pkg::key_t key,
			input bmhq_pkg::pay_t pay);
		result_t          r;
		bmhq_pkg::entry_t tmp;
		int               pos;
		int               up;
		int               best;
		logic             moving;
		r = NO_RESULT;
		if (op == KIND_INS) begin
			if (held >= bmhq_pkg::CAPACITY) begin
				r.status = bmhq_pkg::ST_FULL;
			end else begin
				pos = held;
				heap_shadow[pos].key = key;
				heap_shadow[pos].pay = pay;
				held++;
				moving = 1'b1;
				while (moving && pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_shadow[pos].key < heap_shadow[up].key) begin
						tmp = heap_shadow[pos];
						heap_shadow[pos] = heap_shadow[up];
						heap_shadow[up] = tmp;
						pos = up;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end else begin
			if (held == 0) begin
				r.status = bmhq_pkg::ST_EMPTY;
			end else begin
				r.gone_key = heap_shadow[0].key;
				r.gone_pay = heap_shadow[0].pay;
				held--;
				if (held > 0) begin
					heap_shadow[0] = heap_shadow[held];
					pos = 0;
					moving = 1'b1;
					while (moving) begin
						best = pos;
						if (2 * pos + 1 < held
								&& heap_shadow[2 * pos + 1].key < heap_shadow[best].key)
							best = 2 * pos + 1;
						if (2 * pos + 2 < held
								&& heap_shadow[2 * pos + 2].key < heap_shadow[best].key)
							best = 2 * pos + 2;
						if (best == pos) begin
							moving = 1'b0;
						end else begin
							tmp = heap_shadow[pos];
							heap_shadow[pos] = heap_shadow[best];
							heap_shadow[best] = tmp;
							pos = best;
						end
					end
				end
			end
		end
		if (held > 0) begin
			r.root_key = heap_shadow[0].key;
			r.root_pay = heap_shadow[0].pay;
		end
		r.empty = (held == 0);
		r.count = bmhq_pkg::cnt_t'(held);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Offer one item: idle for a drawn number of cycles, then hold start until
	// the block takes the item. Start is never lowered and raised in one step.
	task automatic issue(input logic op, input bmhq_pkg::key_t key,
			input bmhq_pkg::pay_t pay, input pinned_t pin);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pinned_q.push_back(pin);
		start <= 1'b1;
		kind <= op;
		new_key <= key;
		new_payload <= pay;
		do @(posedge clk); while (busy);
	endtask

	// Scoreboard. Retire a finished result first: the block may hand back one
	// result and take the next item at the same edge.
	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (expected_q.size() == 0) begin
				$error("result with no item pending: status %0d", status);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("removed_key", want.gone_key, removed_key);
				check_field("removed_payload", 32'(want.gone_pay), 32'(removed_payload));
				check_field("min_key", want.root_key, min_key);
				check_field("min_payload", 32'(want.root_pay), 32'(min_payload));
				check_field("is_empty", 32'(want.empty), 32'(is_empty));
				check_field("entry_total", 32'(want.count), 32'(entry_total));
			end
		end
		if (start && busy === 1'b0) begin
			// Advance the shadow heap always; a typed-in result overrides it.
			predicted = heap_apply(kind, new_key, new_payload);
			pin_now = pinned_q.pop_front();
			expected_q.push_back(pin_now.valid ? pin_now.res : predicted);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int             phase;
		int             n;
		int             ins_pct;
		int             spin;
		logic           op;
		bmhq_pkg::key_t key;
		pinned_t        free_pin;

		free_pin = '{1'b0, NO_RESULT};

		// Hold reset, then release away from the rising edge.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < ROWS; n++)
			issue(plan[n].kind, plan[n].key, plan[n].pay, plan[n].pin);

		// Random phases: fill (runs into full), drain (runs into empty), mixed.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 3)
				0:       ins_pct = FILL_PCT;
				1:       ins_pct = DRAIN_PCT;
				default: ins_pct = MIX_PCT;
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Toggle stretches of back-to-back items now and then.
				if (n % 20 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				op = ($urandom_range(0, 99) < ins_pct) ? KIND_INS : KIND_EXT;
				// Mix wide keys, a narrow range for ties, and the extremes.
				case ($urandom_range(0, 3))
					0: key = $urandom_range(0, 7);
					1: begin
						case ($urandom_range(0, 3))
							0:       key = 32'h0;
							1:       key = 32'hFFFF_FFFF;
							2:       key = 32'h7FFF_FFFF;
							default: key = 32'h8000_0000;
						endcase
					end
					default: key = $urandom;
				endcase
				issue(op, key, bmhq_pkg::pay_t'($urandom_range(0, 65535)), free_pin);
			end
		end

		// Drop start and let the last results come home.
		start <= 1'b0;
		@(posedge clk);
		for (spin = 0; spin < DRAIN_LIMIT && expected_q.size() != 0; spin++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== binary_min_heap_queue.f =====
rtl/bmhq_pkg.sv
rtl/binary_min_heap_queue.sv
test/binary_min_heap_queue_test.sv
